// ===== design/voa_pkg.sv =====
// Package: shared constants, codes and helpers for the voice allocator.
`default_nettype none
package voa_pkg;

	localparam int CHANNELS = 16;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int TIME_W = 64;
	localparam int MS_W = 32;
	localparam int US_PER_MS = 1000;
	localparam int REM_W = $clog2(US_PER_MS);
	localparam int DIV_DIGIT_W = 16;
	localparam int DIV_CYCLES = TIME_W / DIV_DIGIT_W;
	localparam int DIV_CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	// one digit step divides {remainder, digit} by US_PER_MS with a reciprocal
	localparam int DIV_X_W = REM_W + DIV_DIGIT_W;
	localparam int DIV_SHIFT = DIV_X_W + REM_W;
	localparam longint DIV_MAGIC = ((longint'(1) << DIV_SHIFT) + longint'(US_PER_MS) - 1)
		/ longint'(US_PER_MS);
	localparam int DIV_MAGIC_W = $clog2(DIV_MAGIC + 1);

	localparam logic [7:0] INVALID_SOUND = 8'd255;

	localparam logic KIND_PLAY = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef logic [2:0] status_t;
	localparam status_t ST_FREE_USED = 3'd0;
	localparam status_t ST_STOLEN = 3'd1;
	localparam status_t ST_MUTED = 3'd2;
	localparam status_t ST_INVALID = 3'd3;
	localparam status_t ST_FREED = 3'd4;

	typedef logic [CH_W-1:0] chan_t;

	// channel field carries the low four bits of the channel number
	function automatic logic [3:0] chan_field(input chan_t idx);
		logic [CH_W+3:0] tmp;
		tmp = {4'b0000, idx};
		return tmp[3:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/voa_in_if.sv =====
// Interface: request channel into the voice allocator.
`default_nettype none
interface voa_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  sound_id;
	logic [63:0] time_us;
	logic [3:0]  done_channel;

	modport source (output valid, kind, sound_id, time_us, done_channel, input ready);
	modport sink (input valid, kind, sound_id, time_us, done_channel, output ready);
endinterface
`default_nettype wire

// ===== design/voa_out_if.sv =====
// Interface: result channel out of the voice allocator.
`default_nettype none
interface voa_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] channel;
	logic [7:0] play_sound;

	modport source (output valid, status, channel, play_sound, input ready);
	modport sink (input valid, status, channel, play_sound, output ready);
endinterface
`default_nettype wire

// ===== design/voa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module voa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== design/voa_ms_div.sv =====
// Iterative divider: microseconds to milliseconds, sixteen quotient bits per cycle.
`default_nettype none
module voa_ms_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [voa_pkg::TIME_W-1:0]  time_us,
	output logic                             done,
	output logic      [voa_pkg::MS_W-1:0]    ms
);
	import voa_pkg::*;

	logic [TIME_W-1:0]              dvd_q;
	logic [REM_W-1:0]               rem_q;
	logic [DIV_CNT_W-1:0]           cnt_q;
	logic                           run_q;
	logic                           done_q;
	logic [TIME_W-1:0]              dvd_nx;
	logic [REM_W-1:0]               rem_nx;
	logic [DIV_X_W-1:0]             dig_x;
	logic [DIV_X_W+DIV_MAGIC_W-1:0] dig_prod;
	logic [DIV_DIGIT_W-1:0]         dig_q;
	logic [DIV_X_W-1:0]             dig_r;

	// long division by digits; quotient digit from a reciprocal multiply,
	// quotient digits shift in where dividend digits leave
	always_comb begin
		dig_x = {rem_q, dvd_q[TIME_W-1 -: DIV_DIGIT_W]};
		dig_prod = (DIV_X_W+DIV_MAGIC_W)'(dig_x) * (DIV_X_W+DIV_MAGIC_W)'(DIV_MAGIC);
		dig_q = dig_prod[DIV_SHIFT +: DIV_DIGIT_W];
		dig_r = dig_x - DIV_X_W'(dig_q) * DIV_X_W'(US_PER_MS);
		dvd_nx = {dvd_q[TIME_W-DIV_DIGIT_W-1:0], dig_q};
		rem_nx = dig_r[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q <= time_us;
				rem_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				dvd_q <= dvd_nx;
				rem_q <= rem_nx;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign ms = dvd_q[MS_W-1:0];
endmodule
`default_nettype wire

// ===== design/voice_allocator_oldest_steal_top.sv =====
// Voice allocator: hands out playback channels, stealing the oldest when full.
//
// Requests come in on req (valid/ready); results leave on rsp (valid/ready),
// one result per request, except a finished event for a channel beyond the
// channel count, which gives none. cfg_we/cfg_wdata write the mute flag.
// One request is worked on at a time; req.ready is high only when idle.
// A finished event, a muted request or an invalid handle goes from S_IDLE
// straight to S_EMIT and then into the output register. A play request first
// converts time_us to milliseconds in an iterative divider (sixteen quotient
// bits per step), then takes the lowest free channel from the busy flags.
// When every channel is busy, the start times are read from the timestamp RAM
// one channel per cycle and compared; the oldest channel is stolen.
// The result sits in an output register, so the next request is accepted
// while rsp is stalled; a further result waits until that register drains.
// Reset clears all busy flags, the mute flag and the output register at once;
// timestamps are only read for busy channels, so the RAM needs no clearing.
`default_nettype none
module voice_allocator_oldest_steal_top (
	input  wire logic clk,
	input  wire logic arst_n,
	voa_in_if.sink    req,
	voa_out_if.source rsp,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata
);
	import voa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_PICK,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t               state_q;
	logic                 muted_q;
	logic [CHANNELS-1:0]  busy_q;
	logic [7:0]           snd_q;
	logic [MS_W-1:0]      ms_q;
	status_t              res_status_q;
	chan_t                res_chan_q;
	logic [7:0]           res_snd_q;
	logic                 out_v_q;
	status_t              out_status_q;
	logic [3:0]           out_chan_q;
	logic [7:0]           out_snd_q;
	chan_t                rd_idx_q;
	logic                 iss_q;
	logic                 cmp_v_s1;
	chan_t                cmp_idx_s1;
	logic [MS_W-1:0]      best_age_q;
	chan_t                best_q;

	logic                 accept;
	logic                 div_start;
	logic                 div_done;
	logic [MS_W-1:0]      div_ms;
	logic                 free_any;
	chan_t                free_idx;
	logic [MS_W-1:0]      ram_rdata;
	logic [MS_W-1:0]      age;
	logic                 age_upd;
	chan_t                best_sel;
	logic                 scan_last;
	logic                 ram_we;
	chan_t                ram_waddr;
	logic                 ram_re;
	logic                 done_ok;
	logic                 emit_go;

	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;
	assign done_ok = (32'(req.done_channel) < CHANNELS);
	assign div_start = accept && (req.kind == KIND_PLAY) && !muted_q
		&& (req.sound_id != INVALID_SOUND);
	assign emit_go = (state_q == S_EMIT) && (!out_v_q || rsp.ready);

	voa_ms_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.time_us (req.time_us),
		.done    (div_done),
		.ms      (div_ms)
	);

	always_comb begin
		free_any = ~&busy_q;
		free_idx = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_idx = chan_t'(i);
			end
		end
	end

	// wrapping age; strict compare keeps ties on the lower channel
	assign age = ms_q - ram_rdata;
	assign age_upd = age > best_age_q;
	assign best_sel = age_upd ? cmp_idx_s1 : best_q;
	assign scan_last = cmp_v_s1 && (cmp_idx_s1 == chan_t'(CHANNELS - 1));

	assign ram_re = (state_q == S_SCAN) && iss_q;
	assign ram_we = ((state_q == S_PICK) && free_any) || ((state_q == S_SCAN) && scan_last);
	assign ram_waddr = (state_q == S_PICK) ? free_idx : best_sel;

	voa_ram #(
		.WIDTH (MS_W),
		.DEPTH (CHANNELS)
	) u_start_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ms_q),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			muted_q <= 1'b0;
			busy_q <= '0;
			out_v_q <= 1'b0;
			iss_q <= 1'b0;
			cmp_v_s1 <= 1'b0;
			snd_q <= '0;
			ms_q <= '0;
			res_status_q <= ST_FREE_USED;
			res_chan_q <= '0;
			res_snd_q <= '0;
			out_status_q <= ST_FREE_USED;
			out_chan_q <= '0;
			out_snd_q <= '0;
			rd_idx_q <= '0;
			cmp_idx_s1 <= '0;
			best_age_q <= '0;
			best_q <= '0;
		end else begin
			if (cfg_we) begin
				muted_q <= cfg_wdata;
			end
			if (emit_go) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			cmp_v_s1 <= (state_q == S_SCAN) && iss_q;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						snd_q <= req.sound_id;
						res_chan_q <= (req.kind == KIND_DONE) ? chan_t'(req.done_channel) : '0;
						res_snd_q <= '0;
						if (req.kind == KIND_DONE) begin
							if (done_ok) begin
								for (int i = 0; i < CHANNELS; i++) begin
									if (32'(i) == 32'(req.done_channel)) begin
										busy_q[i] <= 1'b0;
									end
								end
								res_status_q <= ST_FREED;
								state_q <= S_EMIT;
							end
						end else if (muted_q) begin
							res_status_q <= ST_MUTED;
							state_q <= S_EMIT;
						end else if (req.sound_id == INVALID_SOUND) begin
							res_status_q <= ST_INVALID;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						ms_q <= div_ms;
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					res_snd_q <= snd_q;
					if (free_any) begin
						busy_q[free_idx] <= 1'b1;
						res_status_q <= ST_FREE_USED;
						res_chan_q <= free_idx;
						state_q <= S_EMIT;
					end else begin
						rd_idx_q <= '0;
						iss_q <= 1'b1;
						best_age_q <= '0;
						best_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (iss_q) begin
						cmp_idx_s1 <= rd_idx_q;
						rd_idx_q <= rd_idx_q + 1'b1;
						if (rd_idx_q == chan_t'(CHANNELS - 1)) begin
							iss_q <= 1'b0;
						end
					end
					if (cmp_v_s1) begin
						if (age_upd) begin
							best_age_q <= age;
							best_q <= cmp_idx_s1;
						end
						if (scan_last) begin
							busy_q[best_sel] <= 1'b1;
							res_status_q <= ST_STOLEN;
							res_chan_q <= best_sel;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_status_q <= res_status_q;
						out_chan_q <= chan_field(res_chan_q);
						out_snd_q <= res_snd_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.status = out_status_q;
	assign rsp.channel = out_chan_q;
	assign rsp.play_sound = out_snd_q;
endmodule
`default_nettype wire
